[rtl/hcr_pkg.sv]
// Shared types, constants and the byte-wide CRC-32 step for the header-framed
// CRC-32 receiver. No dependencies; every other file depends on this package.
package hcr_pkg;

  localparam int PAYLOAD_BYTES = 68;
  localparam int HEADER_LEN    = 6;
  localparam int CRC_LEN       = 4;
  localparam int INDEX_W       = 7;
  localparam int HDR_W         = 8 * HEADER_LEN;
  localparam int CRC_W         = 32;

  localparam logic [HDR_W-1:0] HEADER_RESET = 48'h486561646572;
  localparam logic [CRC_W-1:0] CRC_POLY     = 32'hEDB88320;
  localparam logic [CRC_W-1:0] CRC_INIT     = 32'hFFFFFFFF;

  // Command queue between the front and the back; depth is a power of two.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [3:0] {
    PH_HUNT = 4'b0001,
    PH_HEAD = 4'b0010,
    PH_DATA = 4'b0100,
    PH_CRC  = 4'b1000
  } hcr_phase_t;

  typedef enum logic [1:0] {
    OP_DATA   = 2'd0,
    OP_CRC    = 2'd1,
    OP_REJECT = 2'd2
  } hcr_op_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD   = 2'd0,
    KIND_FRAME_END = 2'd1,
    KIND_REJECT    = 2'd2
  } hcr_kind_t;

  // One classified item: payload byte with its index, CRC byte with its
  // position, or a header rejection.
  typedef struct packed {
    hcr_op_t              op;
    logic [7:0]           data;
    logic [INDEX_W-1:0]   index;
  } hcr_cmd_t;

  typedef struct packed {
    logic     push;
    hcr_cmd_t cmd;
  } hcr_push_t;

  typedef struct packed {
    logic     valid;
    hcr_cmd_t cmd;
  } hcr_head_t;

  function automatic logic [7:0] hdr_byte(input logic [HDR_W-1:0] pattern,
                                          input logic [2:0] pos);
    logic [7:0] b;
    case (pos)
      3'd0:    b = pattern[47:40];
      3'd1:    b = pattern[39:32];
      3'd2:    b = pattern[31:24];
      3'd3:    b = pattern[23:16];
      3'd4:    b = pattern[15:8];
      3'd5:    b = pattern[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // Reflected CRC-32, one byte: eight shift steps on a 32-bit value.
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
                                                input logic [7:0] b);
    logic [CRC_W-1:0] c;
    c = crc_in ^ {24'h000000, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) c = (c >> 1) ^ CRC_POLY;
      else      c = c >> 1;
    end
    return c;
  endfunction

endpackage

[rtl/hcr_if.sv]
// Valid/ready channel interfaces for received bytes and result items.
// Depends on hcr_pkg for field widths.
interface hcr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface hcr_result_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  kind;
  logic [7:0]                  data;
  logic [hcr_pkg::INDEX_W-1:0] index;
  logic                        crc_ok;

  modport source (output valid, output kind, output data, output index,
                  output crc_ok, input ready);
  modport sink   (input valid, input kind, input data, input index,
                  input crc_ok, output ready);
endinterface

[rtl/hcr_front.sv]
// Front end: accepts bytes, hunts and checks the header, classifies the rest
// into commands for the queue. Depends on hcr_pkg.
module hcr_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [hcr_pkg::HDR_W-1:0]  cfg_wdata,
  input  logic                       accept,
  input  logic [7:0]                 rx_byte,
  output hcr_pkg::hcr_push_t         push_out
);
  import hcr_pkg::*;

  logic [HDR_W-1:0]   header_pattern;
  hcr_phase_t         phase, phase_next;
  logic [INDEX_W-1:0] byte_count, byte_count_next;
  logic               matched, matched_next;
  logic               byte_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_pattern <= HEADER_RESET;
    end else if (cfg_we) begin
      header_pattern <= cfg_wdata;
    end
  end

  always_comb begin
    phase_next      = phase;
    byte_count_next = byte_count;
    matched_next    = matched;
    push_out        = '0;
    push_out.cmd.op = OP_DATA;
    byte_ok         = (rx_byte == hdr_byte(header_pattern, byte_count[2:0]));
    if (accept) begin
      unique case (phase)
        PH_HUNT: begin
          if (rx_byte == hdr_byte(header_pattern, 3'd0)) begin
            phase_next      = PH_HEAD;
            byte_count_next = INDEX_W'(1);
            matched_next    = 1'b1;
          end
        end
        PH_HEAD: begin
          if (byte_count == INDEX_W'(HEADER_LEN - 1)) begin
            byte_count_next = '0;
            matched_next    = 1'b1;
            if (matched && byte_ok) begin
              phase_next = PH_DATA;
            end else begin
              phase_next      = PH_HUNT;
              push_out.push   = 1'b1;
              push_out.cmd.op = OP_REJECT;
            end
          end else begin
            byte_count_next = byte_count + INDEX_W'(1);
            matched_next    = matched & byte_ok;
          end
        end
        PH_DATA: begin
          push_out.push       = 1'b1;
          push_out.cmd.op     = OP_DATA;
          push_out.cmd.data   = rx_byte;
          push_out.cmd.index  = byte_count;
          if (byte_count == INDEX_W'(PAYLOAD_BYTES - 1)) begin
            phase_next      = PH_CRC;
            byte_count_next = '0;
          end else begin
            byte_count_next = byte_count + INDEX_W'(1);
          end
        end
        PH_CRC: begin
          push_out.push       = 1'b1;
          push_out.cmd.op     = OP_CRC;
          push_out.cmd.data   = rx_byte;
          push_out.cmd.index  = byte_count;
          if (byte_count == INDEX_W'(CRC_LEN - 1)) begin
            phase_next      = PH_HUNT;
            byte_count_next = '0;
          end else begin
            byte_count_next = byte_count + INDEX_W'(1);
          end
        end
        default: begin
          phase_next      = PH_HUNT;
          byte_count_next = '0;
          matched_next    = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HUNT;
      byte_count <= '0;
      matched    <= 1'b1;
    end else begin
      phase      <= phase_next;
      byte_count <= byte_count_next;
      matched    <= matched_next;
    end
  end

  a_head_count: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_HEAD) |-> (byte_count != '0 && byte_count < INDEX_W'(HEADER_LEN)))
    else $error("header byte count out of range");

endmodule

[rtl/hcr_cmd_queue.sv]
// Short command queue between front and back; the head is read combinationally
// from the entry registers. Depends on hcr_pkg.
module hcr_cmd_queue (
  input  logic               clk,
  input  logic               rst,
  input  hcr_pkg::hcr_push_t push_in,
  input  logic               pop,
  output logic               full,
  output hcr_pkg::hcr_head_t head
);
  import hcr_pkg::*;

  hcr_cmd_t          entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_pop;

  assign full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign head.valid = (count != '0);
  assign head.cmd   = entries[rd_ptr];
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (push_in.push) begin
      entries[wr_ptr] <= push_in.cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_in.push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (do_pop)       rd_ptr <= rd_ptr + QPTR_W'(1);
      case ({push_in.push, do_pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push_in.push |-> !full)
    else $error("push into full command queue");

  a_pop_moves_ptr: assert property (@(posedge clk) disable iff (rst)
    (do_pop && !push_in.push) |=> (count == $past(count) - QCNT_W'(1)))
    else $error("queue count did not drop on pop");

endmodule

[rtl/hcr_back.sv]
// Back end: runs the CRC over payload commands, collects the received CRC and
// drives the result register. Depends on hcr_pkg and hcr_result_if.
module hcr_back (
  input  logic               clk,
  input  logic               rst,
  input  hcr_pkg::hcr_head_t head,
  output logic               pop,
  hcr_result_if.source       result
);
  import hcr_pkg::*;

  logic [CRC_W-1:0] running_crc;
  logic [23:0]      received_crc;
  logic             out_valid;
  logic [1:0]       out_kind;
  logic [7:0]       out_data;
  logic [INDEX_W-1:0] out_index;
  logic             out_ok;
  logic             can_load;
  logic             emits;
  logic             crc_last;

  assign can_load = !out_valid || result.ready;
  assign crc_last = (head.cmd.index[1:0] == 2'(CRC_LEN - 1));

  always_comb begin
    case (head.cmd.op)
      OP_CRC:  emits = crc_last;
      default: emits = 1'b1;
    endcase
  end

  assign pop = head.valid && (!emits || can_load);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      running_crc <= CRC_INIT;
    end else begin
      if (result.ready) out_valid <= 1'b0;
      if (pop) begin
        case (head.cmd.op)
          OP_DATA: begin
            running_crc <= crc_byte(running_crc, head.cmd.data);
            out_valid   <= 1'b1;
          end
          OP_CRC: begin
            if (crc_last) begin
              running_crc <= CRC_INIT;
              out_valid   <= 1'b1;
            end
          end
          default: out_valid <= 1'b1;
        endcase
      end
    end
  end

  // Collect the first three CRC bytes; the fourth is compared straight from
  // the command.
  always_ff @(posedge clk) begin
    if (pop && head.cmd.op == OP_CRC) begin
      case (head.cmd.index[1:0])
        2'd0:    received_crc[7:0]   <= head.cmd.data;
        2'd1:    received_crc[15:8]  <= head.cmd.data;
        2'd2:    received_crc[23:16] <= head.cmd.data;
        default: received_crc        <= received_crc;
      endcase
    end
  end

  // Load the result register only for commands that produce an item; hold
  // a waiting result while silent CRC bytes drain past it.
  always_ff @(posedge clk) begin
    if (pop && emits) begin
      out_kind  <= KIND_REJECT;
      out_data  <= 8'h00;
      out_index <= '0;
      out_ok    <= 1'b0;
      case (head.cmd.op)
        OP_DATA: begin
          out_kind  <= KIND_PAYLOAD;
          out_data  <= head.cmd.data;
          out_index <= head.cmd.index;
        end
        OP_CRC: begin
          out_kind <= KIND_FRAME_END;
          out_ok   <= ({head.cmd.data, received_crc} == ~running_crc);
        end
        default: out_kind <= KIND_REJECT;
      endcase
    end
  end

  assign result.valid  = out_valid;
  assign result.kind   = out_kind;
  assign result.data   = out_data;
  assign result.index  = out_index;
  assign result.crc_ok = out_ok;

  a_non_payload_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.kind != KIND_PAYLOAD) |->
      (result.data == 8'h00 && result.index == '0))
    else $error("non-payload result carries data or index");

endmodule

[rtl/header_framed_crc32_receiver_unit.sv]
// Header-framed CRC-32 receiver, top level. Depends on hcr_pkg, hcr_if,
// hcr_front, hcr_cmd_queue and hcr_back.
//
// Throughput: one byte per cycle while the command queue has room; the
//   byte-wide CRC step in the back end and the header compare in the front
//   end are both combinational. Result path: a byte that causes a result
//   reaches the result channel through its command queue entry, then the
//   result register; rx.ready drops only while the four-entry command queue is full.
// Reset (rst, synchronous, active high): hunt for a header, empty the queue,
//   drop any pending result, set the CRC to all ones and the header pattern
//   to "Header".
module header_framed_crc32_receiver_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [hcr_pkg::HDR_W-1:0] cfg_wdata,
  hcr_byte_if.sink                  rx,
  hcr_result_if.source              result
);
  import hcr_pkg::*;

  hcr_push_t push;
  hcr_head_t head;
  logic      queue_full;
  logic      pop;
  logic      accept;

  // Accept a byte whenever the queue has room, even for bytes that
  // turn into no command; the back end drains the queue on its own.
  assign rx.ready = !queue_full;
  assign accept   = rx.valid && rx.ready;

  // Classify: hunt, header check, payload index, CRC byte position.
  hcr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .rx_byte   (rx.rx_byte),
    .push_out  (push)
  );

  // Decouple the two halves so a stalled result does not stall the link until the queue is full.
  hcr_cmd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push_in (push),
    .pop     (pop),
    .full    (queue_full),
    .head    (head)
  );

  // Carry out commands: CRC update, CRC collection, result register.
  hcr_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .pop    (pop),
    .result (result)
  );

endmodule
